>>> src/piecewise_linear_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

`ifndef SYNTH

`define PLI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PLI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, codes and control types of the interpolator unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int DIV_CNT_W   = $clog2(FRAC_W);
    localparam int ENTRY_W     = 6;
    localparam int POINTS_W    = 7;
    localparam int CFG_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [POINTS_W-1:0] POINTS_RESET = 7'd64;

    localparam logic [0:0] REG_POINTS_IN_USE = 1'b0;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REGION_INSIDE = 2'd0,
        REGION_BELOW  = 2'd1,
        REGION_ABOVE  = 2'd2
    } region_t;

    typedef enum logic [2:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_MID,
        ADDR_LOW,
        ADDR_HIGH
    } addr_src_t;

    typedef enum logic [1:0] {
        RES_RD_Y,
        RES_LOW_Y,
        RES_INTERP
    } res_src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_RD_LAST,
        ST_CHK_LAST,
        ST_SR_RD,
        ST_SR_CMP,
        ST_RD_LOW,
        ST_RD_HIGH,
        ST_CAP_HIGH,
        ST_DIFF,
        ST_CHK_DX,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic      in_ready;
        logic      load_query;
        addr_src_t rd_src;
        logic      search_init;
        logic      search_step;
        logic      cap_low;
        logic      cap_high;
        logic      diff;
        logic      div_init;
        logic      div_step;
        logic      mul;
        logic      set_res;
        res_src_t  res_src;
        region_t   res_region;
        logic      load_out;
    } pli_cmd_t;

    typedef struct packed {
        logic le_first;
        logic ge_last;
        logic search_done;
        logic flat;
        logic out_free;
    } pli_status_t;

endpackage

>>> src/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for table writes, clamping checks, search, division and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_unit_macros.svh"

module pli_ctrl
    import pli_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_mode,
    input  pli_status_t status,
    output pli_cmd_t    cmd
);

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.rd_src   = ADDR_FIRST;
        cmd.res_src  = RES_RD_Y;
        cmd.res_region = REGION_INSIDE;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid && s_mode == MODE_QUERY) begin
                    cmd.load_query = 1'b1;
                    state_next     = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST: begin
                cmd.rd_src = ADDR_FIRST;
                state_next = ST_CHK_FIRST;
            end
            ST_CHK_FIRST: begin
                if (status.le_first) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RES_RD_Y;
                    cmd.res_region = REGION_BELOW;
                    state_next     = ST_PUSH;
                end else begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST: begin
                cmd.rd_src = ADDR_LAST;
                state_next = ST_CHK_LAST;
            end
            ST_CHK_LAST: begin
                if (status.ge_last) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RES_RD_Y;
                    cmd.res_region = REGION_ABOVE;
                    state_next     = ST_PUSH;
                end else begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SR_RD;
                end
            end
            ST_SR_RD: begin
                if (status.search_done) begin
                    state_next = ST_RD_LOW;
                end else begin
                    cmd.rd_src = ADDR_MID;
                    state_next = ST_SR_CMP;
                end
            end
            ST_SR_CMP: begin
                cmd.search_step = 1'b1;
                state_next      = ST_SR_RD;
            end
            ST_RD_LOW: begin
                cmd.rd_src = ADDR_LOW;
                state_next = ST_RD_HIGH;
            end
            ST_RD_HIGH: begin
                cmd.rd_src  = ADDR_HIGH;
                cmd.cap_low = 1'b1;
                state_next  = ST_CAP_HIGH;
            end
            ST_CAP_HIGH: begin
                cmd.cap_high = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_CHK_DX;
            end
            ST_CHK_DX: begin
                if (status.flat) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_src    = RES_LOW_Y;
                    cmd.res_region = REGION_INSIDE;
                    state_next     = ST_PUSH;
                end else begin
                    cmd.div_init = 1'b1;
                    div_cnt_next = DIV_CNT_W'(FRAC_W - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0) begin
                    state_next = ST_MUL;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.set_res    = 1'b1;
                cmd.res_src    = RES_INTERP;
                cmd.res_region = REGION_INSIDE;
                state_next     = ST_PUSH;
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PLI_ASSERT_NEXT(a_query_starts, aclk, aresetn, cmd.in_ready && s_tvalid && s_mode == MODE_QUERY, state_reg == ST_RD_FIRST, "accepted query did not start a table read")
    `PLI_ASSERT_IMPLIES(a_mul_after_div, aclk, aresetn, state_reg == ST_MUL, $past(state_reg) == ST_DIV, "multiply entered without division")

endmodule

>>> src/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Breakpoint tables, search indices, divider, multiplier and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_unit_macros.svh"

module pli_datapath
    import pli_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pli_cmd_t                 cmd,
    output pli_status_t              status,
    input  logic [POINTS_W-1:0]      points_in_use,
    input  logic                     s_tvalid,
    input  logic                     s_mode,
    input  logic [ENTRY_W-1:0]       entry_index,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  logic signed [DATA_W-1:0] query_value,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] result_value,
    output region_t                  region
);

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_x_raw, rd_y_raw;
    logic signed [DATA_W-1:0] rd_x, rd_y;

    logic [CNT_W-1:0]         n_cnt, mid_cnt, idx_cnt, low_cnt;
    logic [CNT_W-1:0]         lo_reg, lo_next, hi_reg, hi_next;

    logic signed [DATA_W-1:0] query_reg;
    logic signed [DATA_W-1:0] xl_reg, yl_reg, xh_reg, yh_reg;
    logic signed [DATA_W:0]   dx_reg, dy_reg, num_full;
    logic [DATA_W:0]          num_reg;
    logic [DATA_W+1:0]        rem_reg, rem_shift;
    logic [FRAC_W-1:0]        quot_reg, t_val;
    logic                     sat_reg;
    logic signed [DATA_W+FRAC_W+1:0] prod_reg, prod_next;
    logic signed [DATA_W+1:0] prod_floor;
    logic signed [DATA_W+2:0] sum_val;
    logic signed [DATA_W-1:0] interp_val, res_mux;
    logic signed [DATA_W-1:0] res_val_reg;
    region_t                  res_region_reg;
    logic                     m_tvalid_reg;
    logic signed [DATA_W-1:0] m_value_reg;
    region_t                  m_region_reg;

    assign wr_en = cmd.in_ready && s_tvalid && s_mode == MODE_WRITE
                   && 32'(entry_index) < TABLE_DEPTH;
    assign wr_addr = ADDR_W'(entry_index);

    always_comb begin
        if (points_in_use == '0) begin
            n_cnt = CNT_W'(1);
        end else if (32'(points_in_use) > TABLE_DEPTH) begin
            n_cnt = CNT_W'(TABLE_DEPTH);
        end else begin
            n_cnt = CNT_W'(points_in_use);
        end
        mid_cnt = lo_reg + ((hi_reg - lo_reg) >> 1);
        if (lo_reg == '0) begin
            idx_cnt = CNT_W'(1);
        end else if (lo_reg > n_cnt - 1'b1) begin
            idx_cnt = n_cnt - 1'b1;
        end else begin
            idx_cnt = lo_reg;
        end
        low_cnt = idx_cnt - 1'b1;
    end

    always_comb begin
        unique case (cmd.rd_src)
            ADDR_FIRST: rd_addr = '0;
            ADDR_LAST:  rd_addr = ADDR_W'(n_cnt - 1'b1);
            ADDR_MID:   rd_addr = ADDR_W'(mid_cnt);
            ADDR_LOW:   rd_addr = ADDR_W'(low_cnt);
            ADDR_HIGH:  rd_addr = ADDR_W'(idx_cnt);
            default:    rd_addr = '0;
        endcase
    end

    pli_ram #(
        .WIDTH(DATA_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table_x (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (point_x),
        .rd_addr (rd_addr),
        .rd_data (rd_x_raw)
    );

    pli_ram #(
        .WIDTH(DATA_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table_y (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (point_y),
        .rd_addr (rd_addr),
        .rd_data (rd_y_raw)
    );

    assign rd_x = $signed(rd_x_raw);
    assign rd_y = $signed(rd_y_raw);

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.search_init) begin
            lo_next = '0;
            hi_next = n_cnt;
        end else if (cmd.search_step) begin
            if (rd_x <= query_reg) begin
                lo_next = mid_cnt + 1'b1;
            end else begin
                hi_next = mid_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign num_full  = {query_reg[DATA_W-1], query_reg} - {xl_reg[DATA_W-1], xl_reg};
    assign rem_shift = {rem_reg[DATA_W:0], 1'b0};
    assign t_val     = sat_reg ? '1 : quot_reg;
    assign prod_next = $signed({1'b0, t_val}) * dy_reg;
    assign prod_floor = prod_reg[DATA_W+FRAC_W+1:FRAC_W];
    assign sum_val   = {{3{yl_reg[DATA_W-1]}}, yl_reg} + {prod_floor[DATA_W+1], prod_floor};

    always_comb begin
        if (sum_val[DATA_W+2:DATA_W-1] == '0 || sum_val[DATA_W+2:DATA_W-1] == '1) begin
            interp_val = sum_val[DATA_W-1:0];
        end else if (sum_val[DATA_W+2]) begin
            interp_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            interp_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        unique case (cmd.res_src)
            RES_RD_Y:   res_mux = rd_y;
            RES_LOW_Y:  res_mux = yl_reg;
            RES_INTERP: res_mux = interp_val;
            default:    res_mux = rd_y;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            query_reg <= query_value;
        end
        if (cmd.cap_low) begin
            xl_reg <= rd_x;
            yl_reg <= rd_y;
        end
        if (cmd.cap_high) begin
            xh_reg <= rd_x;
            yh_reg <= rd_y;
        end
        if (cmd.diff) begin
            dx_reg  <= {xh_reg[DATA_W-1], xh_reg} - {xl_reg[DATA_W-1], xl_reg};
            dy_reg  <= {yh_reg[DATA_W-1], yh_reg} - {yl_reg[DATA_W-1], yl_reg};
            num_reg <= num_full[DATA_W] ? '0 : num_full;
        end
        if (cmd.div_init) begin
            rem_reg  <= {1'b0, num_reg};
            quot_reg <= '0;
            sat_reg  <= num_reg >= dx_reg;
        end else if (cmd.div_step) begin
            if (rem_shift >= {1'b0, dx_reg}) begin
                rem_reg  <= rem_shift - {1'b0, dx_reg};
                quot_reg <= {quot_reg[FRAC_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift;
                quot_reg <= {quot_reg[FRAC_W-2:0], 1'b0};
            end
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.set_res) begin
            res_val_reg    <= res_mux;
            res_region_reg <= cmd.res_region;
        end
        if (cmd.load_out) begin
            m_value_reg  <= res_val_reg;
            m_region_reg <= res_region_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.le_first    = query_reg <= rd_x;
    assign status.ge_last     = query_reg >= rd_x;
    assign status.search_done = lo_reg >= hi_reg;
    assign status.flat        = dx_reg <= 0;
    assign status.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid     = m_tvalid_reg;
    assign result_value = m_value_reg;
    assign region       = m_region_reg;

    `PLI_ASSERT_IMPLIES(a_step_open, aclk, aresetn, cmd.search_step, lo_reg < hi_reg, "search stepped on an empty interval")
    `PLI_ASSERT_NEXT(a_search_bounds, aclk, aresetn, cmd.search_step, lo_reg <= hi_reg, "search bounds crossed")
    `PLI_ASSERT_IMPLIES(a_out_from_push, aclk, aresetn, $rose(m_tvalid_reg), $past(cmd.load_out), "result appeared without a push")

endmodule

>>> src/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// Breakpoint table with clamped linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// The input stream carries requests. With s_tuser low a request writes one
// breakpoint into the slot given by entry_index and produces no result. With
// s_tuser high a request queries the table and produces exactly one result on
// the output stream, with the region code in m_tuser. A query that clamps
// below the first breakpoint reads and compares it before the result is
// pushed; one that clamps above the last also reads and compares the last. An
// interior query runs a binary search of up to seven probes (one table read
// port), a restoring division for the fraction and one multiply; the next
// request is taken in the cycle after the result is loaded.
// One request is in work at a time; s_tready is high only when the
// sequencer is idle. A finished result sits in an output register, so the
// next request is taken while the receiver stalls; a second result then waits
// until the first is taken. Reset empties the pipeline, drops any pending
// result and sets points_in_use to 64. Table contents are not cleared and
// must be written before they are queried. points_in_use is written over the
// APB port at address 0; the user must write it only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_interpolator_unit
    import pli_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: entry_index[5:0], point_x[37:6], point_y[69:38],
    // query_value[101:70], zero pad[103:102]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [103:0]          s_tdata,
    // s_tuser: mode[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: result_value[31:0]
    output logic [31:0]           m_tdata,
    // m_tuser: region[1:0]
    output logic [1:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    pli_cmd_t              cmd;
    pli_status_t           status;
    logic [POINTS_W-1:0]   points_reg;
    logic signed [DATA_W-1:0] result_value;
    region_t               region;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= POINTS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_POINTS_IN_USE) begin
            points_reg <= pwdata[POINTS_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_POINTS_IN_USE) begin
            prdata = APB_DATA_W'(points_reg);
        end else begin
            prdata = '0;
        end
    end

    pli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    pli_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .points_in_use (points_reg),
        .s_tvalid      (s_tvalid),
        .s_mode        (s_tuser[0]),
        .entry_index   (s_tdata[5:0]),
        .point_x       ($signed(s_tdata[37:6])),
        .point_y       ($signed(s_tdata[69:38])),
        .query_value   ($signed(s_tdata[101:70])),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .result_value  (result_value),
        .region        (region)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = result_value;
    assign m_tuser  = region;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator unit testbench
// Loads breakpoint tables over the request stream and queries them. Each
// result is checked against a predictor that keeps its own copy of the table
// and the point count. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import pli_pkg::*;

    typedef logic signed [31:0] q16_t;

    typedef struct {
        logic [31:0] value;
        region_t     zone;
    } lookup_t;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } rx_pattern_t;

    typedef enum int {
        TABLE_SORTED,
        TABLE_DENSE,
        TABLE_REPEATS,
        TABLE_UNSORTED
    } table_style_t;

    localparam int    SETTLE_CYCLES  = 60;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    PHASE_QUERIES  = 45;
    localparam longint Q16_MAX       = 64'sd2147483647;
    localparam longint Q16_MIN       = -64'sd2147483648;
    localparam q16_t  X_MIN          = 32'sh8000_0000;
    localparam q16_t  X_MAX          = 32'sh7FFF_FFFF;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [103:0]          s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    q16_t                  bp_x [TABLE_DEPTH];
    q16_t                  bp_y [TABLE_DEPTH];
    logic [POINTS_W-1:0]   points_setting;
    lookup_t               pending_lookups [$];
    int                    mismatch_count = 0;
    int                    burst_left = 0;
    int                    quiet_cycles = 0;
    rx_pattern_t           rx_pattern = RX_ALWAYS;
    logic [15:0]           rx_cycle = '0;

    piecewise_linear_interpolator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    function automatic int active_points();
        if (points_setting == 0) begin
            return 1;
        end
        if (points_setting > TABLE_DEPTH) begin
            return TABLE_DEPTH;
        end
        return int'(points_setting);
    endfunction

    function automatic lookup_t interpolate_table(input q16_t q);
        lookup_t r;
        int      n;
        int      lo;
        int      hi;
        int      mid;
        int      low;
        longint  dx;
        longint  num;
        longint  frac;
        longint  acc;
        n = active_points();
        if (q <= bp_x[0]) begin
            r.value = bp_y[0];
            r.zone  = REGION_BELOW;
            return r;
        end
        if (q >= bp_x[n-1]) begin
            r.value = bp_y[n-1];
            r.zone  = REGION_ABOVE;
            return r;
        end
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (bp_x[mid] <= q) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (lo < 1) lo = 1;
        if (lo > n - 1) lo = n - 1;
        low = lo - 1;
        r.zone = REGION_INSIDE;
        dx = longint'(bp_x[low+1]) - longint'(bp_x[low]);
        if (dx <= 0) begin
            r.value = bp_y[low];
            return r;
        end
        num = longint'(q) - longint'(bp_x[low]);
        if (num < 0) num = 0;
        frac = (num <<< 16) / dx;
        if (frac > 65535) frac = 65535;
        acc = longint'(bp_y[low])
            + ((frac * (longint'(bp_y[low+1]) - longint'(bp_y[low]))) >>> 16);
        if (acc > Q16_MAX) acc = Q16_MAX;
        if (acc < Q16_MIN) acc = Q16_MIN;
        r.value = q16_t'(acc);
        return r;
    endfunction

    function automatic q16_t pick_query(input int n);
        longint lo_x;
        longint hi_x;
        longint pick;
        int     k;
        lo_x = bp_x[0];
        hi_x = bp_x[n-1];
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (hi_x > lo_x) begin
                    pick = lo_x + longint'({$urandom, $urandom} >> 1) % (hi_x - lo_x + 1);
                end else begin
                    pick = $signed($urandom);
                end
            end
            4, 5: pick = bp_x[k];
            6: pick = longint'(bp_x[k]) + ($urandom_range(0, 1) ? 1 : -1);
            7: pick = lo_x - longint'($urandom_range(0, 100));
            8: pick = hi_x + longint'($urandom_range(0, 100));
            default: pick = $signed($urandom);
        endcase
        if (pick > Q16_MAX) pick = Q16_MAX;
        if (pick < Q16_MIN) pick = Q16_MIN;
        return q16_t'(pick);
    endfunction

    task automatic send_item(input logic mode, input logic [ENTRY_W-1:0] slot,
                             input q16_t px, input q16_t py, input q16_t qv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, qv, py, px, slot};
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_WRITE) begin
            bp_x[slot] = px;
            bp_y[slot] = py;
        end else begin
            pending_lookups.insert(pending_lookups.size(), interpolate_table(qv));
        end
    endtask

    task automatic write_point(input int slot, input q16_t px, input q16_t py);
        send_item(MODE_WRITE, ENTRY_W'(slot), px, py, $urandom);
    endtask

    task automatic query_at(input q16_t qv);
        send_item(MODE_QUERY, ENTRY_W'($urandom), $urandom, $urandom, qv);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_lookups.size() != 0) @(posedge aclk);
    endtask

    task automatic set_point_count(input int count);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_POINTS_IN_USE, 2'b00};
        pwdata  <= APB_DATA_W'(count);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        points_setting = POINTS_W'(count);
    endtask

    task automatic load_table(input int count, input table_style_t style);
        q16_t   xs [TABLE_DEPTH];
        q16_t   ys [TABLE_DEPTH];
        q16_t   held;
        longint walk;
        int     i;
        int     j;
        walk = $signed($urandom);
        for (i = 0; i < count; i++) begin
            ys[i] = $urandom;
            case (style)
                TABLE_DENSE: begin
                    walk = walk + longint'($urandom_range(1, 1 << 18));
                    if (walk > Q16_MAX) walk = Q16_MAX;
                    xs[i] = q16_t'(walk);
                    ys[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                end
                TABLE_REPEATS: begin
                    xs[i] = (i > 0 && $urandom_range(0, 2) == 0) ? xs[i-1] : $urandom;
                end
                default: xs[i] = $urandom;
            endcase
        end
        if (style != TABLE_UNSORTED) begin
            for (i = 1; i < count; i++) begin
                held = xs[i];
                j = i - 1;
                while (j >= 0 && xs[j] > held) begin
                    xs[j+1] = xs[j];
                    j--;
                end
                xs[j+1] = held;
            end
        end
        for (i = 0; i < count; i++) begin
            write_point(i, xs[i], ys[i]);
        end
    endtask

    task automatic test_extreme_table();
        set_point_count(4);
        write_point(0, X_MIN, X_MAX);
        write_point(1, -1, X_MIN);
        write_point(2, -1, 32'sh0003_0000);
        write_point(3, X_MAX, -1);
        query_at(X_MIN);
        query_at(X_MAX);
        query_at(-2);
        query_at(-1);
        query_at(32'sh4000_0000);
    endtask

    task automatic test_fraction_rounding();
        set_point_count(2);
        write_point(0, 0, 7);
        write_point(1, 32'sh0003_0000, -7);
        query_at(1);
        query_at(32'sh0001_0000);
        query_at(32'sh0002_FFFF);
    endtask

    task automatic test_single_breakpoint();
        set_point_count(1);
        query_at(0);
        query_at(-5);
        query_at(1);
        query_at(X_MAX);
        set_point_count(0);
        query_at(X_MIN);
        query_at(5);
    endtask

    task automatic test_random_tables();
        int settings [10];
        int setting;
        int n;
        int p;
        int i;
        settings = '{64, 127, 0, 1, 2, 0, 0, 0, 0, 0};
        for (p = 0; p < 10; p++) begin
            setting = (p >= 5) ? $urandom_range(3, 16) : settings[p];
            set_point_count(setting);
            n = active_points();
            load_table(n, table_style_t'(p % 4));
            for (i = 0; i < PHASE_QUERIES; i++) begin
                if (i == PHASE_QUERIES / 2) begin
                    wait_until_drained();
                end
                if ($urandom_range(0, 7) == 0) begin
                    write_point($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
                end else begin
                    query_at(pick_query(n));
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[7:0] == 8'd0) begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
        end
        case (rx_pattern)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_tready <= (rx_cycle[2:0] < 3'd3);
            default:     m_tready <= (rx_cycle[4:0] < 5'd4);
        endcase
    end

    always @(posedge aclk) begin
        lookup_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lookups.size() == 0) begin
                $error("result with no request waiting: result_value %h region %0d",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (m_tdata !== want.value) begin
                    $error("result_value: expected %h, actual %h", want.value, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.zone) begin
                    $error("region: expected %0d, actual %0d", want.zone, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_WRITE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        points_setting = POINTS_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_table();
        test_fraction_rounding();
        test_single_breakpoint();
        test_random_tables();

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
